### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge of clock
`define DTL_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define DTL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/dtl_pkg.sv
package dtl_pkg;

   localparam int RootBits = 31;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [30:0] EPS_Q30 = 31'd10737;
   localparam logic [31:0] INV_PI_Q30 = 32'd341782638;

   typedef logic [29:0] angle_step_type;
   localparam angle_step_type ATAN_TABLE [0:9] = '{
      30'd268435456, 30'd158466703, 30'd83729454, 30'd42502378, 30'd21333666,
      30'd10677233, 30'd5339919, 30'd2670123, 30'd1335082, 30'd667543
   };

   // rotation angle of CORDIC step i in half turns, Q0.30
   function automatic angle_step_type atan_step(input int i);
      logic [31:0] acc;
      acc = '0;
      if (i < 10) begin
         return ATAN_TABLE[i];
      end
      acc = (INV_PI_Q30 + (32'd1 << (i - 1))) >> i;
      return acc[29:0];
   endfunction

endpackage

### hw/rtl/dtl_sqrt.sv
module dtl_sqrt #(
   parameter int SideWidth = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [60:0]          in_n,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [30:0]          out_root,
   output logic [SideWidth-1:0] out_side
);
   import dtl_pkg::*;

   logic                 valid_ff [0:RootBits];
   logic [63:0]          rem_ff   [0:RootBits];
   logic [30:0]          root_ff  [0:RootBits];
   logic [SideWidth-1:0] side_ff  [0:RootBits];

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else valid_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= {3'b0, in_n};
      root_ff[0] <= '0;
      side_ff[0] <= in_side;
   end

   // one root bit per stage, most significant first
   for (genvar s = 0; s < RootBits; s++) begin : g_step
      localparam int K = RootBits - 1 - s;
      logic [63:0] trial;
      logic        take;

      assign trial = ({33'b0, root_ff[s]} << (K + 1)) + (64'd1 << (2 * K));
      assign take  = rem_ff[s] >= trial;

      always_ff @(posedge clock) begin
         if (reset) valid_ff[s+1] <= 1'b0;
         else valid_ff[s+1] <= valid_ff[s];
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= take ? rem_ff[s] - trial : rem_ff[s];
         root_ff[s+1] <= root_ff[s] | ({30'b0, take} << K);
         side_ff[s+1] <= side_ff[s];
      end
   end

   assign out_valid = valid_ff[RootBits];
   assign out_root  = root_ff[RootBits];
   assign out_side  = side_ff[RootBits];

endmodule

### hw/rtl/dtl_cordic.sv
module dtl_cordic #(
   parameter int Iterations = 16,
   parameter int SideWidth  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [31:0]   in_x,
   input  logic signed [31:0]   in_y,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic signed [32:0]   out_angle,
   output logic [SideWidth-1:0] out_side
);
   import dtl_pkg::*;

   logic                 valid_ff [0:Iterations];
   logic signed [33:0]   x_ff     [0:Iterations];
   logic signed [33:0]   y_ff     [0:Iterations];
   logic signed [32:0]   z_ff     [0:Iterations];
   logic [SideWidth-1:0] side_ff  [0:Iterations];

   logic signed [33:0] x_ext;
   logic signed [33:0] y_ext;
   logic signed [33:0] x_in;
   logic signed [33:0] y_in;
   logic signed [32:0] z_in;

   assign x_ext = 34'(in_x);
   assign y_ext = 34'(in_y);

   // turn a left-half-plane vector by a quarter turn first
   always_comb begin
      x_in = x_ext;
      y_in = y_ext;
      z_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in = y_ext;
            y_in = -x_ext;
            z_in = 33'sh0_2000_0000;
         end else begin
            x_in = -y_ext;
            y_in = x_ext;
            z_in = -33'sh0_2000_0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else valid_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= x_in;
      y_ff[0]    <= y_in;
      z_ff[0]    <= z_in;
      side_ff[0] <= in_side;
   end

   for (genvar i = 0; i < Iterations; i++) begin : g_iter
      localparam logic signed [32:0] Step = 33'(atan_step(i));
      logic signed [33:0] dx;
      logic signed [33:0] dy;

      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else valid_ff[i+1] <= valid_ff[i];
      end

      always_ff @(posedge clock) begin
         if (!y_ff[i][33]) begin
            x_ff[i+1] <= x_ff[i] + dy;
            y_ff[i+1] <= y_ff[i] - dx;
            z_ff[i+1] <= z_ff[i] + Step;
         end else begin
            x_ff[i+1] <= x_ff[i] - dy;
            y_ff[i+1] <= y_ff[i] + dx;
            z_ff[i+1] <= z_ff[i] - Step;
         end
         side_ff[i+1] <= side_ff[i];
      end
   end

   assign out_valid = valid_ff[Iterations];
   assign out_angle = z_ff[Iterations];
   assign out_side  = side_ff[Iterations];

endmodule

### hw/rtl/direction_to_latlong_uv.sv
// Maps a direction (Q1.15 x, y, z) to equirectangular map coordinates u, v
// (Q0.16). A request is taken every cycle (busy is always low) and its result
// appears on rsp_valid in request order; the receiver cannot stall. The path
// runs through an input register, two 31-stage square-root pipelines, two
// CORDIC pipelines of ANGLE_ITERATIONS stages each, a 31-stage restoring
// divider, clamp and square registers and an output register.
module direction_to_latlong_uv #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_dir_x,
   input  logic [15:0] req_dir_y,
   input  logic [15:0] req_dir_z,
   output logic        rsp_valid,
   output logic [15:0] rsp_u_coord,
   output logic [15:0] rsp_v_coord
);
   import dtl_pkg::*;
   `include "assert_macros.svh"

   assign busy = 1'b0;

   // input register
   logic        in_v_ff;
   logic        xneg_ff;
   logic [15:0] y_ff;
   logic [15:0] z_ff;

   always_ff @(posedge clock) begin
      if (reset) in_v_ff <= 1'b0;
      else in_v_ff <= start;
   end

   always_ff @(posedge clock) begin
      xneg_ff <= req_dir_x[15];
      y_ff    <= req_dir_y;
      z_ff    <= req_dir_z;
   end

   // cos(latitude) = sqrt(1 - y^2)
   logic signed [31:0] ysq;
   logic [30:0]        lat_rem;
   logic               s1_v;
   logic [30:0]        cos_lat;
   logic [32:0]        s1_side;

   assign ysq     = $signed(y_ff) * $signed(y_ff);
   assign lat_rem = ONE_Q30 - ysq[30:0];

   dtl_sqrt #(.SideWidth(33)) u_sqrt_lat (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_v_ff),
      .in_n     ({lat_rem, 30'b0}),
      .in_side  ({xneg_ff, z_ff, y_ff}),
      .out_valid(s1_v),
      .out_root (cos_lat),
      .out_side (s1_side)
   );

   // latitude = atan2(y, cos_lat)
   logic signed [31:0] lat_ys;
   logic               c1_v;
   logic signed [32:0] lat;
   logic [47:0]        c1_side;

   assign lat_ys = {s1_side[15], s1_side[15:0], 15'b0};

   dtl_cordic #(.Iterations(ANGLE_ITERATIONS), .SideWidth(48)) u_cordic_lat (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_v),
      .in_x     ({1'b0, cos_lat}),
      .in_y     (lat_ys),
      .in_side  ({s1_side[32:16], cos_lat}),
      .out_valid(c1_v),
      .out_angle(lat),
      .out_side (c1_side)
   );

   // cos(longitude) magnitude = (|z| << 45) / (cos_lat + eps)
   logic [15:0] zmag;
   logic [30:0] den_in;
   logic [61:0] num_in;

   assign zmag   = c1_side[46] ? 16'(-c1_side[46:31]) : c1_side[46:31];
   assign den_in = c1_side[30:0] + EPS_Q30;
   assign num_in = {1'b0, zmag, 45'b0};

   logic        dv_ff   [0:RootBits];
   logic [61:0] drem_ff [0:RootBits];
   logic [30:0] dq_ff   [0:RootBits];
   logic [30:0] dden_ff [0:RootBits];
   logic        dsat_ff [0:RootBits];
   logic [34:0] dside_ff[0:RootBits];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else dv_ff[0] <= c1_v;
   end

   always_ff @(posedge clock) begin
      drem_ff[0]  <= num_in;
      dq_ff[0]    <= '0;
      dden_ff[0]  <= den_in;
      dsat_ff[0]  <= num_in >= {den_in, 31'b0};
      dside_ff[0] <= {c1_side[47], c1_side[46], lat};
   end

   for (genvar s = 0; s < RootBits; s++) begin : g_div
      localparam int K = RootBits - 1 - s;
      logic [61:0] sub;
      logic        take;

      assign sub  = {31'b0, dden_ff[s]} << K;
      assign take = drem_ff[s] >= sub;

      always_ff @(posedge clock) begin
         if (reset) dv_ff[s+1] <= 1'b0;
         else dv_ff[s+1] <= dv_ff[s];
      end

      always_ff @(posedge clock) begin
         drem_ff[s+1]  <= take ? drem_ff[s] - sub : drem_ff[s];
         dq_ff[s+1]    <= dq_ff[s] | ({30'b0, take} << K);
         dden_ff[s+1]  <= dden_ff[s];
         dsat_ff[s+1]  <= dsat_ff[s];
         dside_ff[s+1] <= dside_ff[s];
      end
   end

   // clamp to 1.0, then square
   logic        clamp_v_ff;
   logic [30:0] cmag_ff;
   logic [34:0] clamp_side_ff;
   logic        sq_v_ff;
   logic [61:0] sq_ff;
   logic [30:0] sq_cmag_ff;
   logic [34:0] sq_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_v_ff <= 1'b0;
         sq_v_ff    <= 1'b0;
      end else begin
         clamp_v_ff <= dv_ff[RootBits];
         sq_v_ff    <= clamp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmag_ff       <= (dsat_ff[RootBits] || dq_ff[RootBits] > ONE_Q30)
                       ? ONE_Q30 : dq_ff[RootBits];
      clamp_side_ff <= dside_ff[RootBits];
      sq_ff         <= cmag_ff * cmag_ff;
      sq_cmag_ff    <= cmag_ff;
      sq_side_ff    <= clamp_side_ff;
   end

   // sin(longitude) = sqrt(1 - cos^2)
   logic [60:0] lon_rem;
   logic        s2_v;
   logic [30:0] sin_long;
   logic [65:0] s2_side;

   assign lon_rem = 61'h1000_0000_0000_0000 - sq_ff[60:0];

   dtl_sqrt #(.SideWidth(66)) u_sqrt_lon (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sq_v_ff),
      .in_n     (lon_rem),
      .in_side  ({sq_side_ff[34], sq_side_ff[33], sq_cmag_ff, sq_side_ff[32:0]}),
      .out_valid(s2_v),
      .out_root (sin_long),
      .out_side (s2_side)
   );

   // longitude = atan2(sin, cos)
   logic signed [31:0] cos_long;
   logic               c2_v;
   logic signed [32:0] lon;
   logic [33:0]        c2_side;

   assign cos_long = s2_side[64] ? -$signed({1'b0, s2_side[63:33]})
                                 : $signed({1'b0, s2_side[63:33]});

   dtl_cordic #(.Iterations(ANGLE_ITERATIONS), .SideWidth(34)) u_cordic_lon (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_v),
      .in_x     (cos_long),
      .in_y     ({1'b0, sin_long}),
      .in_side  ({s2_side[65], s2_side[32:0]}),
      .out_valid(c2_v),
      .out_angle(lon),
      .out_side (c2_side)
   );

   // scale to Q0.16 with rounding and saturation
   logic signed [34:0] lon_fix;
   logic signed [34:0] tu;
   logic signed [34:0] tv;
   logic [15:0]        u_in;
   logic [15:0]        v_in;

   always_comb begin
      lon_fix = c2_side[33] ? -35'(lon) : 35'(lon);
      tu = lon_fix + 35'sh0_4000_4000;
      tv = 35'(signed'(c2_side[32:0])) + 35'sh0_2000_2000;
      if (tu < 0) u_in = '0;
      else if (tu[34:15] > 20'd65535) u_in = 16'hFFFF;
      else u_in = tu[30:15];
      if (tv < 0) v_in = '0;
      else if (tv[34:14] > 21'd65535) v_in = 16'hFFFF;
      else v_in = tv[29:14];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= c2_v;
   end

   always_ff @(posedge clock) begin
      rsp_u_coord <= u_in;
      rsp_v_coord <= v_in;
   end

   `DTL_ASSERT_IMPLIES(a_cmag_range, clamp_v_ff, cmag_ff <= ONE_Q30)
   `DTL_ASSERT_NEXT(a_sq_range, clamp_v_ff, sq_ff <= 62'h1000_0000_0000_0000)

endmodule

### tb/sv/uv_checker.sv
module uv_checker #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_dir_x,
   input  logic [15:0] req_dir_y,
   input  logic [15:0] req_dir_z,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_u_coord,
   input  logic [15:0] rsp_v_coord,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_Q30 = 64'sd1 << 30;
   localparam longint EPS_Q30 = 10737;
   localparam longint INV_PI = 341782638;
   localparam int MAX_STEPS = 30;

   typedef struct packed {
      logic [15:0] u_coord;
      logic [15:0] v_coord;
   } uv_type;

   uv_type expected_uv[$];

   function automatic longint turn_step(input int i);
      longint steps [0:9];
      steps = '{268435456, 158466703, 83729454, 42502378, 21333666,
                10677233, 5339919, 2670123, 1335082, 667543};
      if (i < 10) begin
         return steps[i];
      end
      return (INV_PI + (64'sd1 << (i - 1))) >>> i;
   endfunction

   function automatic longint int_sqrt(input logic [63:0] n);
      logic [63:0] root, bit_w;
      root = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
         if (n >= root + bit_w) begin
            n = n - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root >>= 1;
         end
         bit_w >>= 2;
      end
      return longint'(root);
   endfunction

   // atan2 in half turns, Q2.30
   function automatic longint vector_angle(input longint ys, input longint xs);
      longint x, y, z, dx, dy;
      x = xs;
      y = ys;
      z = 0;
      if (xs < 0) begin
         if (ys >= 0) begin
            x = ys; y = -xs; z = ONE_Q30 / 2;
         end else begin
            x = -ys; y = xs; z = -(ONE_Q30 / 2);
         end
      end
      for (int i = 0; i < ANGLE_ITERATIONS && i < MAX_STEPS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x += dy; y -= dx; z += turn_step(i);
         end else begin
            x -= dy; y += dx; z -= turn_step(i);
         end
      end
      return z;
   endfunction

   function automatic logic [15:0] sat_q16(input longint t, input int shift);
      if (t < 0) begin
         return 16'd0;
      end
      t = t >>> shift;
      return (t > 65535) ? 16'hFFFF : t[15:0];
   endfunction

   function automatic uv_type map_direction(input logic [15:0] dx, input logic [15:0] dy,
                                            input logic [15:0] dz);
      longint x, y, z, cos_lat, lat, lon, cos_long, sin_long;
      logic [63:0] cmag, zmag, den;
      uv_type r;
      x = longint'($signed(dx));
      y = longint'($signed(dy));
      z = longint'($signed(dz));
      cos_lat = int_sqrt(64'(ONE_Q30 - y * y) << 30);
      lat = vector_angle(y * 32768, cos_lat);
      den = 64'(cos_lat + EPS_Q30);
      zmag = 64'(z < 0 ? -z : z);
      cmag = (zmag << 45) / den;
      if (cmag > 64'(ONE_Q30)) cmag = 64'(ONE_Q30);
      cos_long = (z < 0) ? -longint'(cmag) : longint'(cmag);
      sin_long = int_sqrt((64'd1 << 60) - cmag * cmag);
      lon = vector_angle(sin_long, cos_long);
      if (x < 0) lon = -lon;
      r.u_coord = sat_q16(lon + ONE_Q30 + (64'sd1 << 14), 15);
      r.v_coord = sat_q16(lat + ONE_Q30 / 2 + (64'sd1 << 13), 14);
      return r;
   endfunction

   assign pending = expected_uv.size();

   always @(posedge clock) begin
      uv_type exp_uv;
      if (!reset) begin
         // check first so a same-edge request never matches itself
         if (rsp_valid) begin
            if (expected_uv.size() == 0) begin
               $error("unexpected result u=%0d v=%0d", rsp_u_coord, rsp_v_coord);
               fail_count++;
            end else begin
               exp_uv = expected_uv.pop_front();
               if (rsp_u_coord !== exp_uv.u_coord) begin
                  $error("u_coord expected %0d actual %0d", exp_uv.u_coord, rsp_u_coord);
                  fail_count++;
               end
               if (rsp_v_coord !== exp_uv.v_coord) begin
                  $error("v_coord expected %0d actual %0d", exp_uv.v_coord, rsp_v_coord);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_uv.push_back(map_direction(req_dir_x, req_dir_y, req_dir_z));
         end
      end
   end
endmodule

### tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_ITERATIONS = 16;
   localparam int LATENCY = 2 * ANGLE_ITERATIONS + 102;
   localparam int WATCHDOG_LIMIT = 20 * LATENCY + 1000;
   localparam int RANDOM_REQUESTS = 1350;

   logic        clock, reset, start, busy, rsp_valid;
   logic [15:0] req_dir_x, req_dir_y, req_dir_z, rsp_u_coord, rsp_v_coord;
   int          fail_count, pending, idle_cycles, sender_idle_pct;

   direction_to_latlong_uv #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) i_dut (.*);

   uv_checker #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) i_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_direction(input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] z);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // mostly near-unit vectors, with raw noise and sign/edge codes mixed in
   task automatic send_random;
      logic [15:0] x, y, z;
      real fy, fz, lon;
      int mode;
      mode = int'($urandom_range(9));
      x = 16'($urandom);
      if (mode < 6) begin
         fy = ($urandom_range(65535) / 32768.0) - 1.0;
         lon = ($urandom_range(65535) / 65536.0) * 6.2831853;
         fz = $sqrt(1.0 - fy * fy) * $cos(lon);
         y = 16'($rtoi(fy * 32767.0));
         z = 16'($rtoi(fz * 32767.0));
      end else if (mode < 8) begin
         y = 16'($urandom);
         z = 16'($urandom);
      end else begin
         y = $urandom_range(1) ? 16'h8000 : 16'($urandom_range(3) - 1);
         z = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      end
      send_direction(x, y, z);
   endtask

   initial begin
      logic [15:0] edge_vals [6];
      edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5A82};
      reset = 1'b1;
      start = 1'b0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      sender_idle_pct = 30;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // poles, equator, zero and negative x, longitude of pi, non-unit vectors
      foreach (edge_vals[i]) send_direction(edge_vals[i], edge_vals[i], 16'h7FFF);
      foreach (edge_vals[i]) send_direction(16'h0000, 16'h0000, edge_vals[i]);
      foreach (edge_vals[i]) send_direction(16'hFFFF, edge_vals[(i + 2) % 6],
                                            edge_vals[(i + 1) % 6]);
      send_direction(16'h0000, 16'h0000, 16'h8000);
      send_direction(16'h8000, 16'h0000, 16'h8000);
      send_direction(16'h7FFF, 16'h8000, 16'h8000);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 3) sender_idle_pct = 80;
         if (n == 2 * RANDOM_REQUESTS / 3) sender_idle_pct = 0;
         send_random();
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
